[hdl/bitplane_block_complexity_embed_core_assert.svh]
// Assertion macros for the bit-plane block complexity core.
`ifndef BITPLANE_BLOCK_COMPLEXITY_EMBED_CORE_ASSERT_SVH
`define BITPLANE_BLOCK_COMPLEXITY_EMBED_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BPBCE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPBCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/bpbce_pkg.sv]
`timescale 1ns / 1ps
package bpbce_pkg;

  localparam int WORD_BITS = 64;
  localparam int CNT_W = 7;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_W-1:0] count_t;

  localparam count_t THRESHOLD_RESET = 7'd34;
  localparam count_t COUNT_MAX = 7'd127;

endpackage

[hdl/bitplane_block_complexity_embed_core.sv]
`timescale 1ns / 1ps
// A block passes the input register, then the result register, to out_valid.
// Throughput: one block per cycle unless out_stall holds; input register,
// complexity tree and merge, result register, with the adder tree over the
// neighbor differences in between. Reset: valid flags clear, threshold is 34.
module bitplane_block_complexity_embed_core #(
  parameter int BLOCK_SIDE = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  bpbce_pkg::count_t cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  bpbce_pkg::word_t  plane_block,
  input  bpbce_pkg::word_t  secret_bits,
  input  bpbce_pkg::count_t bits_left,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              eligible,
  output bpbce_pkg::count_t complexity,
  output bpbce_pkg::word_t  new_block,
  output bpbce_pkg::count_t bits_used
);
  import bpbce_pkg::*;

  `include "bitplane_block_complexity_embed_core_assert.svh"

  localparam int CELLS = BLOCK_SIDE * BLOCK_SIDE;
  localparam int LIMIT = (CELLS < WORD_BITS) ? CELLS : WORD_BITS;
  localparam int CX_W = $clog2(2 * BLOCK_SIDE * (BLOCK_SIDE - 1) + 1);
  localparam int CMP_W = (CX_W > CNT_W) ? CX_W : CNT_W;

  count_t threshold;

  logic   s1_valid;
  word_t  blk_q;
  word_t  sec_q;
  count_t left_q;

  logic              s1_adv;
  logic              s2_adv;
  logic [CX_W-1:0]   cx;
  logic [CMP_W-1:0]  cx_ext;
  logic              elig;
  count_t            cx_sat;
  word_t             merged;
  count_t            used;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_write) begin
      threshold <= cfg_data;
    end
  end

  assign s2_adv = !out_valid || !out_stall;
  assign s1_adv = !s1_valid || s2_adv;
  assign in_stall = !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      blk_q <= plane_block;
      sec_q <= secret_bits;
      left_q <= bits_left;
    end
  end

  bpbce_complexity #(
    .BLOCK_SIDE (BLOCK_SIDE),
    .CX_W       (CX_W)
  ) u_complexity (
    .blk   (blk_q),
    .count (cx)
  );

  assign cx_ext = CMP_W'(cx);
  assign elig = cx_ext >= CMP_W'(threshold);
  // saturate the reported count; eligibility uses the full count
  assign cx_sat = (cx_ext > CMP_W'(COUNT_MAX)) ? COUNT_MAX : cx_ext[CNT_W-1:0];

  bpbce_embed #(
    .LIMIT (LIMIT)
  ) u_embed (
    .blk      (blk_q),
    .secret   (sec_q),
    .left     (left_q),
    .eligible (elig),
    .new_blk  (merged),
    .used     (used)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid) begin
      eligible <= elig;
      complexity <= cx_sat;
      new_block <= merged;
      bits_used <= used;
    end
  end

  `BPBCE_ASSERT_NOW(a_stall_full, in_stall, s1_valid && out_valid, "stall with empty stage")
  `BPBCE_ASSERT_NOW(a_unused_zero, out_valid && !eligible, bits_used == '0,
    "bits used on ineligible block")
  `BPBCE_ASSERT_NOW(a_used_limit, out_valid, bits_used <= CNT_W'(LIMIT), "bits used above limit")
  `BPBCE_ASSERT_NEXT(a_s1_hold, s1_valid && !s2_adv,
    s1_valid && $stable(blk_q) && $stable(left_q), "held input stage changed")

endmodule

[hdl/bpbce_complexity.sv]
`timescale 1ns / 1ps
module bpbce_complexity #(
  parameter int BLOCK_SIDE = 8,
  parameter int CX_W = 7
) (
  input  bpbce_pkg::word_t blk,
  output logic [CX_W-1:0]  count
);
  import bpbce_pkg::*;

  localparam int CELLS = BLOCK_SIDE * BLOCK_SIDE;
  localparam int PAIRS = BLOCK_SIDE * (BLOCK_SIDE - 1);
  localparam int ND = 2 * PAIRS;
  localparam int LEAVES = 2 ** $clog2(ND);

  logic [CELLS-1:0] cellv;
  logic [ND-1:0]    diff;
  logic [CX_W-1:0]  node [2*LEAVES-1];

  // cells past the stored word read as zero
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    if (k < WORD_BITS) begin : g_stored
      assign cellv[k] = blk[k];
    end else begin : g_empty
      assign cellv[k] = 1'b0;
    end
  end

  for (genvar r = 0; r < BLOCK_SIDE; r++) begin : g_row
    for (genvar c = 0; c < BLOCK_SIDE - 1; c++) begin : g_horz
      assign diff[r*(BLOCK_SIDE-1)+c] = cellv[r*BLOCK_SIDE+c] ^ cellv[r*BLOCK_SIDE+c+1];
    end
  end

  for (genvar r = 0; r < BLOCK_SIDE - 1; r++) begin : g_vrow
    for (genvar c = 0; c < BLOCK_SIDE; c++) begin : g_vert
      assign diff[PAIRS+r*BLOCK_SIDE+c] = cellv[r*BLOCK_SIDE+c] ^ cellv[(r+1)*BLOCK_SIDE+c];
    end
  end

  // balanced adder tree over the difference bits
  for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
    if (k < ND) begin : g_used
      assign node[LEAVES-1+k] = CX_W'(diff[k]);
    end else begin : g_pad
      assign node[LEAVES-1+k] = '0;
    end
  end

  for (genvar n = 0; n < LEAVES - 1; n++) begin : g_sum
    assign node[n] = node[2*n+1] + node[2*n+2];
  end

  assign count = node[0];

endmodule

[hdl/bpbce_embed.sv]
`timescale 1ns / 1ps
module bpbce_embed #(
  parameter int LIMIT = 64
) (
  input  bpbce_pkg::word_t  blk,
  input  bpbce_pkg::word_t  secret,
  input  bpbce_pkg::count_t left,
  input  logic              eligible,
  output bpbce_pkg::word_t  new_blk,
  output bpbce_pkg::count_t used
);
  import bpbce_pkg::*;

  count_t capped;
  word_t  mask;

  always_comb begin
    capped = (left > CNT_W'(LIMIT)) ? CNT_W'(LIMIT) : left;
    used = eligible ? capped : '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      mask[k] = CNT_W'(k) < used;
    end
    new_blk = (blk & ~mask) | (secret & mask);
  end

endmodule
